### rtl/core/synth_tuning_word_planner_assert.svh
// ----------------------------------------------------------------------------
// synth_tuning_word_planner_assert.svh
// assertion macros used by the planner checker
// ----------------------------------------------------------------------------
`ifndef SYNTH_TUNING_WORD_PLANNER_ASSERT_SVH
`define SYNTH_TUNING_WORD_PLANNER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define STWP_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stwp assertion failed");

// next-cycle implication
`define STWP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stwp assertion failed");

`endif

### rtl/core/stwp_pkg.sv
// ----------------------------------------------------------------------------
// stwp_pkg
// types, tables and widths shared by the tuning word planner
// ----------------------------------------------------------------------------
`default_nettype none

package stwp_pkg;

  // dividend of the rounded quotient is 2*vco*2^(31-frac) + 1200*K, below 2^47
  localparam int NUM_W  = 47;
  localparam int QUO_W  = 32;
  localparam int REM_W  = NUM_W - QUO_W;
  localparam int DV_W   = 15;
  localparam int VCO_W  = 36;
  localparam int DIV_W  = 14;
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int NSTAGE = QUO_W;

  localparam logic [31:0] WORD_FULL = 32'h8000_0000;
  localparam logic [4:0]  ADDR_BASE = 5'h0B;

  // divider thresholds times 16 in MHz
  localparam logic [16:0] DIV_THR16 [6] = '{
    17'd97120, 17'd48560, 17'd24280, 17'd12140, 17'd6070, 17'd3035
  };

  // exclusive upper edges of the multiplier bands in MHz
  localparam logic [13:0] BAND_TOP [6] = '{
    14'd7020, 14'd8190, 14'd9360, 14'd10530, 14'd11700, 14'd12870
  };

  typedef struct packed {
    logic [13:0] lo;
    logic [13:0] hi;
    logic [3:0]  k;
  } stwp_win_t;

  localparam int NWIN = 30;

  // inclusive exception windows in MHz, the last one can never match
  localparam stwp_win_t WIN [NWIN] = '{
    '{14'd7068,  14'd7080,  4'd6},  '{14'd8030,  14'd8062,  4'd8},
    '{14'd9172,  14'd9175,  4'd9},  '{14'd9181,  14'd9184,  4'd9},
    '{14'd9190,  14'd9220,  4'd9},  '{14'd9390,  14'd9393,  4'd8},
    '{14'd9435,  14'd9464,  4'd8},  '{14'd10315, 14'd10360, 4'd10},
    '{14'd10366, 14'd10370, 4'd10}, '{14'd11019, 14'd11022, 4'd11},
    '{14'd11038, 14'd11042, 4'd11}, '{14'd11057, 14'd11060, 4'd11},
    '{14'd11465, 14'd11469, 4'd11}, '{14'd11476, 14'd11480, 4'd11},
    '{14'd11485, 14'd11512, 4'd11}, '{14'd11519, 14'd11521, 4'd11},
    '{14'd11528, 14'd11531, 4'd11}, '{14'd11545, 14'd11549, 4'd11},
    '{14'd11650, 14'd11687, 4'd11}, '{14'd12050, 14'd12096, 4'd12},
    '{14'd12098, 14'd12124, 4'd12}, '{14'd12142, 14'd12187, 4'd12},
    '{14'd12372, 14'd12378, 4'd12}, '{14'd12584, 14'd12588, 4'd12},
    '{14'd12612, 14'd12615, 4'd12}, '{14'd12635, 14'd12665, 4'd12},
    '{14'd12670, 14'd12684, 4'd12}, '{14'd12700, 14'd12703, 4'd12},
    '{14'd12812, 14'd12856, 4'd12}, '{14'd12958, 14'd12856, 4'd11}
  };

  typedef struct packed {
    logic [2:0] n;
    logic [3:0] k;
    logic [4:0] addr;
    logic       err;
  } stwp_meta_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DV_W-1:0]  dv;
    stwp_meta_t       meta;
  } stwp_item_t;

  // 1200 * K for the legal multipliers
  function automatic logic [DIV_W-1:0] stwp_div(input logic [3:0] k);
    logic [DIV_W-1:0] d;
    case (k)
      4'd6:    d = 14'd7200;
      4'd7:    d = 14'd8400;
      4'd8:    d = 14'd9600;
      4'd9:    d = 14'd10800;
      4'd10:   d = 14'd12000;
      4'd11:   d = 14'd13200;
      4'd12:   d = 14'd14400;
      default: d = 14'd7200;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/core/synth_tuning_word_planner.sv
// ----------------------------------------------------------------------------
// synth_tuning_word_planner
// turns a wanted output frequency into divider, multiplier and dds tuning word
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | to block  | in_valid_i / in_stall_o | freq_q16_i, profile_i
//  out     | from block| out_valid_o/ out_stall_i| tuning_word_o, divider_exp_o,
//          |           |                         | multiplier_k_o, word_address_o,
//          |           |                         | range_error_o
//
// one transaction per cycle in and out unless a stall holds the flow; each
// request passes a 3-stage classifier and a 4-entry queue on its way into the
// 32-stage restoring divider (one quotient bit a stage)
// reset clears valid flags, queue pointers and queue count only; there is no clearing pass
// out_stall_i freezes the divider while a result is valid; the queue absorbs the classifier, and
// in_stall_o rises once the queue is full with an item waiting to enter it
// ----------------------------------------------------------------------------
`default_nettype none

module synth_tuning_word_planner #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [29:0] freq_q16_i,
  input  wire logic [2:0]  profile_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      tuning_word_o,
  output logic [2:0]       divider_exp_o,
  output logic [3:0]       multiplier_k_o,
  output logic [4:0]       word_address_o,
  output logic             range_error_o
);

  logic                 push, pop, q_full, q_valid;
  stwp_pkg::stwp_item_t front_item, q_item;

  stwp_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .freq_q16_i (freq_q16_i),
    .profile_i  (profile_i),
    .full_i     (q_full),
    .push_o     (push),
    .item_o     (front_item)
  );

  stwp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  stwp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (q_valid),
    .item_i         (q_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tuning_word_o  (tuning_word_o),
    .divider_exp_o  (divider_exp_o),
    .multiplier_k_o (multiplier_k_o),
    .word_address_o (word_address_o),
    .range_error_o  (range_error_o)
  );

endmodule

`default_nettype wire

### rtl/core/stwp_front.sv
// ----------------------------------------------------------------------------
// stwp_front
// three-stage classifier: divider exponent, multiplier, range check, dividend
// ----------------------------------------------------------------------------
`default_nettype none

module stwp_front #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [29:0]         freq_q16_i,
  input  wire logic [2:0]          profile_i,
  input  wire logic                full_i,
  output logic                     push_o,
  output stwp_pkg::stwp_item_t     item_o
);

  logic adv;
  logic a_vld_q, b_vld_q, c_vld_q;

  // stage a: exponent and vco
  logic [5:0]                   gt;
  logic [2:0]                   n_d, a_n_q;
  logic [stwp_pkg::VCO_W-1:0]   vco_d, a_vco_q;
  logic [4:0]                   addr_d, a_addr_q;

  // stage b: multiplier and range flag
  logic [5:0]                   lt;
  logic [7:0]                   ovr;
  logic [3:0]                   k_d, b_k_q;
  logic                         err_d, b_err_q;
  logic [2:0]                   b_n_q;
  logic [4:0]                   b_addr_q;
  logic [stwp_pkg::VCO_W-1:0]   b_vco_q;

  // stage c: dividend
  logic [stwp_pkg::VCO_W-1:0]   vco_m;
  logic [stwp_pkg::DIV_W-1:0]   d_c;
  logic [63:0]                  sh;
  stwp_pkg::stwp_item_t         item_d, c_item_q;

  assign adv        = !c_vld_q || !full_i;
  assign in_stall_o = !adv;
  assign push_o     = c_vld_q && !full_i;
  assign item_o     = c_item_q;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      gt[i] = {30'b0, freq_q16_i, 4'b0} > (64'(stwp_pkg::DIV_THR16[i]) << FRAC_BITS);
    end
    n_d = 3'd6;
    for (int i = 5; i >= 0; i--) begin
      if (gt[i]) begin
        n_d = 3'(i);
      end
    end
    vco_d  = stwp_pkg::VCO_W'(freq_q16_i) << n_d;
    addr_d = stwp_pkg::ADDR_BASE + {1'b0, profile_i, 1'b0};
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      lt[i] = 64'(a_vco_q) < (64'(stwp_pkg::BAND_TOP[i]) << FRAC_BITS);
    end
    k_d = 4'd12;
    for (int i = 5; i >= 0; i--) begin
      if (lt[i]) begin
        k_d = 4'(6 + i);
      end
    end
    // later windows take priority
    for (int i = 0; i < stwp_pkg::NWIN; i++) begin
      if (64'(a_vco_q) >= (64'(stwp_pkg::WIN[i].lo) << FRAC_BITS) &&
          64'(a_vco_q) <= (64'(stwp_pkg::WIN[i].hi) << FRAC_BITS)) begin
        k_d = stwp_pkg::WIN[i].k;
      end
    end
    // over-range test for every multiplier in parallel, picked by k
    for (int j = 0; j < 7; j++) begin
      ovr[j] = 64'(a_vco_q) > (64'(1200 * (6 + j)) << FRAC_BITS);
    end
    ovr[7] = 1'b0;
    err_d  = ovr[3'(k_d - 4'd6)];
  end

  always_comb begin
    vco_m            = b_err_q ? '0 : b_vco_q;
    d_c              = stwp_pkg::stwp_div(b_k_q);
    sh               = 64'(vco_m) << (32 - FRAC_BITS);
    item_d.num       = sh[stwp_pkg::NUM_W-1:0] + stwp_pkg::NUM_W'(d_c);
    item_d.dv        = {d_c, 1'b0};
    item_d.meta.n    = b_n_q;
    item_d.meta.k    = b_k_q;
    item_d.meta.addr = b_addr_q;
    item_d.meta.err  = b_err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_n_q    <= n_d;
      a_vco_q  <= vco_d;
      a_addr_q <= addr_d;
      b_n_q    <= a_n_q;
      b_vco_q  <= a_vco_q;
      b_addr_q <= a_addr_q;
      b_k_q    <= k_d;
      b_err_q  <= err_d;
      c_item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/stwp_queue.sv
// ----------------------------------------------------------------------------
// stwp_queue
// short fifo between the classifier and the divider pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module stwp_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  stwp_pkg::stwp_item_t      item_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      valid_o,
  output stwp_pkg::stwp_item_t      item_o
);

  stwp_pkg::stwp_item_t       mem_q [stwp_pkg::QDEPTH];
  logic [stwp_pkg::QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [stwp_pkg::QAW:0]     cnt_q, cnt_d;

  assign full_o  = cnt_q == (stwp_pkg::QAW + 1)'(stwp_pkg::QDEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/stwp_back.sv
// ----------------------------------------------------------------------------
// stwp_back
// pipelined restoring divider, one quotient bit per stage, and output register
// ----------------------------------------------------------------------------
`default_nettype none

module stwp_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 item_valid_i,
  input  stwp_pkg::stwp_item_t      item_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [31:0]               tuning_word_o,
  output logic [2:0]                divider_exp_o,
  output logic [3:0]                multiplier_k_o,
  output logic [4:0]                word_address_o,
  output logic                      range_error_o
);

  localparam int NST = stwp_pkg::NSTAGE;
  localparam int RW  = stwp_pkg::REM_W;
  localparam int QW  = stwp_pkg::QUO_W;
  localparam int DW  = stwp_pkg::DV_W;

  logic adv;

  logic [NST-1:0]       vld_in, vld_q;
  logic [RW-1:0]        rem_in [NST];
  logic [RW-1:0]        rem_d  [NST];
  logic [RW-1:0]        rem_q  [NST];
  logic [QW-1:0]        lo_in  [NST];
  logic [QW-1:0]        lo_d   [NST];
  logic [QW-1:0]        lo_q   [NST];
  logic [QW-1:0]        quo_in [NST];
  logic [QW-1:0]        quo_d  [NST];
  logic [QW-1:0]        quo_q  [NST];
  logic [DW-1:0]        dv_in  [NST];
  logic [DW-1:0]        dv_q   [NST];
  stwp_pkg::stwp_meta_t meta_in [NST];
  stwp_pkg::stwp_meta_t meta_q  [NST];

  logic                 out_vld_q;
  logic [31:0]          word_d, word_q;
  stwp_pkg::stwp_meta_t out_meta_q;

  assign adv   = !out_vld_q || !out_stall_i;
  assign pop_o = adv && item_valid_i;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [RW:0] trial;
    logic        ge;

    if (s == 0) begin : g_head
      assign vld_in[s]  = item_valid_i;
      assign rem_in[s]  = item_i.num[stwp_pkg::NUM_W-1:QW];
      assign lo_in[s]   = item_i.num[QW-1:0];
      assign quo_in[s]  = '0;
      assign dv_in[s]   = item_i.dv;
      assign meta_in[s] = item_i.meta;
    end else begin : g_body
      assign vld_in[s]  = vld_q[s-1];
      assign rem_in[s]  = rem_q[s-1];
      assign lo_in[s]   = lo_q[s-1];
      assign quo_in[s]  = quo_q[s-1];
      assign dv_in[s]   = dv_q[s-1];
      assign meta_in[s] = meta_q[s-1];
    end

    // bring down the next dividend bit and try a subtract
    assign trial    = {rem_in[s], lo_in[s][QW-1]};
    assign ge       = trial >= {1'b0, dv_in[s]};
    assign rem_d[s] = ge ? RW'(trial - {1'b0, dv_in[s]}) : trial[RW-1:0];
    assign lo_d[s]  = {lo_in[s][QW-2:0], 1'b0};
    assign quo_d[s] = {quo_in[s][QW-2:0], ge};
  end

  assign word_d = meta_q[NST-1].err ? '0 : stwp_pkg::WORD_FULL - quo_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= vld_in;
      out_vld_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q      <= rem_d;
      lo_q       <= lo_d;
      quo_q      <= quo_d;
      dv_q       <= dv_in;
      meta_q     <= meta_in;
      word_q     <= word_d;
      out_meta_q <= meta_q[NST-1];
    end
  end

  assign out_valid_o    = out_vld_q;
  assign tuning_word_o  = word_q;
  assign divider_exp_o  = out_meta_q.n;
  assign multiplier_k_o = out_meta_q.k;
  assign word_address_o = out_meta_q.addr;
  assign range_error_o  = out_meta_q.err;

endmodule

`default_nettype wire

### rtl/core/stwp_checker.sv
// ----------------------------------------------------------------------------
// stwp_checker
// port-level checks on the planner's result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "synth_tuning_word_planner_assert.svh"

module stwp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] tuning_word_o,
  input wire logic [2:0]  divider_exp_o,
  input wire logic [3:0]  multiplier_k_o,
  input wire logic [4:0]  word_address_o,
  input wire logic        range_error_o
);

  // a stalled result stays and keeps its word
  `STWP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(tuning_word_o))

  // a zero word on over range
  `STWP_ASSERT(a_err_zero, out_valid_o && range_error_o, tuning_word_o == 32'd0)

  // the word never exceeds its zero-offset value
  `STWP_ASSERT(a_word_max, out_valid_o, tuning_word_o <= 32'h8000_0000)

  // selector fields stay in their legal ranges, address is odd from 0x0B up
  `STWP_ASSERT(a_fields, out_valid_o, multiplier_k_o >= 4'd6 && multiplier_k_o <= 4'd12 && divider_exp_o <= 3'd6 && word_address_o[0] && word_address_o >= 5'd11)

endmodule

bind synth_tuning_word_planner stwp_checker u_stwp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .tuning_word_o  (tuning_word_o),
  .divider_exp_o  (divider_exp_o),
  .multiplier_k_o (multiplier_k_o),
  .word_address_o (word_address_o),
  .range_error_o  (range_error_o)
);

`default_nettype wire
